// File: sv/kclp_pkg.sv
// kclp_pkg: shared types, constants and helpers for the key click / long-press detector
// no dependencies; imported by every other file of the block

package kclp_pkg;

	localparam int KEY_COUNT = 5;
	localparam int LEVEL_W   = 5;
	localparam int KEY_W     = 3;
	localparam int KIND_W    = 2;
	localparam int CNT_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int SLOT_CNT  = 2 * KEY_COUNT;
	localparam int SLOT_W    = $clog2(SLOT_CNT);

	localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

	localparam logic [CNT_W-1:0] DEBOUNCE_RST = 16'd3;
	localparam logic [CNT_W-1:0] LONG_RST     = 16'd100;
	localparam logic [CNT_W-1:0] REPEAT_RST   = 16'd20;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE = 2'd0,
		REG_LONG     = 2'd1,
		REG_REPEAT   = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_PRESSED = 2'd1,
		MODE_LONG    = 2'd2
	} key_mode_t;

	typedef enum logic [KIND_W-1:0] {
		EV_CLICK = 2'd0,
		EV_LONG  = 2'd1,
		EV_HOLD  = 2'd2
	} event_kind_t;

	typedef struct packed {
		logic [CNT_W-1:0] debounce;
		logic [CNT_W-1:0] long_press;
		logic [CNT_W-1:0] repeat_ivl;
	} cfg_t;

	// per key events of one tick: first slot is click or long press, second is hold repeat
	typedef struct packed {
		logic first;
		logic first_long;
		logic hold;
	} key_ev_t;

	typedef struct packed {
		logic pending;
		logic final_beat;
	} q_stat_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : CNT_W'(v + 1'b1);
	endfunction

endpackage

// File: sv/kclp_if.sv
// kclp_if: valid/ready channel interfaces for scan ticks and key events
// depends on kclp_pkg

interface kclp_key_if import kclp_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] pressed_levels;

	modport source (output valid, output pressed_levels, input ready);
	modport sink   (input valid, input pressed_levels, output ready);
endinterface

interface kclp_event_if import kclp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KEY_W-1:0]  key_index;
	logic [KIND_W-1:0] event_kind;
	logic              last_event;

	modport source (output valid, output key_index, output event_kind, output last_event,
		input ready);
	modport sink   (input valid, input key_index, input event_kind, input last_event,
		output ready);
endinterface

// File: sv/kclp_key_unit.sv
// kclp_key_unit: state and next-state logic of one key (level, stable flag, mode, counters)
// depends on kclp_pkg

module kclp_key_unit import kclp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  logic    raw,
	input  cfg_t    cfg,
	output key_ev_t ev
);

	logic             prior_q;
	logic             stable_q;
	key_mode_t        mode_q;
	logic [CNT_W-1:0] press_q;
	logic [CNT_W-1:0] hold_q;

	logic             stable_d;
	key_mode_t        mode_d;
	logic [CNT_W-1:0] press_d;
	logic [CNT_W-1:0] hold_d;
	logic [CNT_W-1:0] pc1;
	logic [CNT_W-1:0] hc1;
	logic             same_press;

	assign same_press = raw && prior_q;
	assign pc1 = same_press ? sat_inc(press_q) : '0;
	assign hc1 = same_press ? hold_q : '0;

	always_comb begin
		stable_d = stable_q;
		mode_d   = mode_q;
		press_d  = pc1;
		hold_d   = hc1;
		ev       = '0;
		if (pc1 >= cfg.debounce) begin
			stable_d = 1'b1;
			if (mode_d == MODE_IDLE) begin
				mode_d  = MODE_PRESSED;
				press_d = '0;
			end
			if (mode_d == MODE_PRESSED) begin
				press_d = sat_inc(press_d);
				if (press_d >= cfg.long_press) begin
					ev.first      = 1'b1;
					ev.first_long = 1'b1;
					mode_d        = MODE_LONG;
					hold_d        = '0;
				end
			end
			if (mode_d == MODE_LONG) begin
				hold_d = sat_inc(hold_d);
				if (hold_d >= cfg.repeat_ivl) begin
					ev.hold = 1'b1;
					hold_d  = '0;
				end
			end
		end else if (stable_q && !raw) begin
			ev.first = (mode_q == MODE_PRESSED) && (pc1 < cfg.long_press);
			mode_d   = MODE_IDLE;
			stable_d = 1'b0;
			press_d  = '0;
			hold_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_q  <= 1'b0;
			stable_q <= 1'b0;
			mode_q   <= MODE_IDLE;
			press_q  <= '0;
			hold_q   <= '0;
		end else if (step) begin
			prior_q  <= raw;
			stable_q <= stable_d;
			mode_q   <= mode_d;
			press_q  <= press_d;
			hold_q   <= hold_d;
		end
	end

endmodule

// File: sv/kclp_event_queue.sv
// kclp_event_queue: result register holding one tick's events as a slot mask, sent lowest first
// depends on kclp_pkg and kclp_if

module kclp_event_queue import kclp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  key_ev_t              ev [KEY_COUNT],
	output q_stat_t              stat,
	kclp_event_if.source         events
);

	logic [SLOT_CNT-1:0]  mask_q;
	logic [KEY_COUNT-1:0] long_q;
	logic [SLOT_CNT-1:0]  mask_d;
	logic [KEY_COUNT-1:0] long_d;
	logic [SLOT_CNT-1:0]  lowest;
	logic [SLOT_CNT-1:0]  rest;
	logic [SLOT_W-1:0]    pos;
	logic [KEY_W-1:0]     key;
	logic                 beat;

	always_comb begin
		for (int i = 0; i < KEY_COUNT; i++) begin
			mask_d[2*i]   = ev[i].first;
			mask_d[2*i+1] = ev[i].hold;
			long_d[i]     = ev[i].first_long;
		end
	end

	assign lowest = mask_q & SLOT_CNT'(~mask_q + 1'b1);
	assign rest   = mask_q & ~lowest;

	always_comb begin
		pos = '0;
		for (int j = 0; j < SLOT_CNT; j++) begin
			if (lowest[j])
				pos = pos | SLOT_W'(j);
		end
	end

	assign key = KEY_W'(pos >> 1);

	assign events.valid      = |mask_q;
	assign events.key_index  = key;
	assign events.last_event = ~|rest;
	always_comb begin
		if (pos[0])
			events.event_kind = EV_HOLD;
		else if (long_q[key])
			events.event_kind = EV_LONG;
		else
			events.event_kind = EV_CLICK;
	end

	assign beat            = events.valid && events.ready;
	assign stat.pending    = |mask_q;
	assign stat.final_beat = ~|rest;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mask_q <= '0;
		else if (load)
			mask_q <= mask_d;
		else if (beat)
			mask_q <= rest;
	end

	always_ff @(posedge clk) begin
		if (load)
			long_q <= long_d;
	end

endmodule

// File: sv/key_click_long_press_detector.sv
// key_click_long_press_detector: top level; config registers, scan tick input register,
// per key units and the event result register. depends on kclp_pkg, kclp_if and submodules
// flow: a tick waits in the scan tick input register until it moves on, then key state and
// the result register update together; events leave one per cycle while events.ready is high
// throughput: one tick per cycle while ticks cause at most one event and events.ready is high;
// reset clears config to 3/100/20, all keys to released and idle, and both stages

module key_click_long_press_detector import kclp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_data,
	kclp_key_if.sink             keys,
	kclp_event_if.source         events
);

	cfg_t               cfg_q;
	logic               valid_s1;
	logic [LEVEL_W-1:0] levels_s1;
	logic               adv;
	q_stat_t            stat;
	key_ev_t            ev [KEY_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce   <= DEBOUNCE_RST;
			cfg_q.long_press <= LONG_RST;
			cfg_q.repeat_ivl <= REPEAT_RST;
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_DEBOUNCE: cfg_q.debounce   <= cfg_data;
				REG_LONG:     cfg_q.long_press <= cfg_data;
				REG_REPEAT:   cfg_q.repeat_ivl <= cfg_data;
				default: ;
			endcase
		end
	end

	// tick moves on once the result register is free or sending its final beat
	assign adv = valid_s1 && (!stat.pending || (events.ready && stat.final_beat));
	assign keys.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (keys.ready)
			valid_s1 <= keys.valid;
	end

	always_ff @(posedge clk) begin
		if (keys.ready && keys.valid)
			levels_s1 <= keys.pressed_levels;
	end

	for (genvar i = 0; i < KEY_COUNT; i++) begin : g_key
		kclp_key_unit u_key (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (adv),
			.raw    (levels_s1[i]),
			.cfg    (cfg_q),
			.ev     (ev[i])
		);
	end

	kclp_event_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (adv),
		.ev     (ev),
		.stat   (stat),
		.events (events)
	);

endmodule
